>>> sv/whti_pkg.sv
// Shared types, constants and character classes for the word hash table.
// Used by whti_ctrl, whti_dp and word_hash_table_insert; depends on nothing.
`default_nettype none

package whti_pkg;

    localparam int TABLE_SIZE   = 1024;
    localparam int MAX_WORD_LEN = 32;

    localparam int CHAR_W     = 8;
    localparam int TE_W       = 11;
    localparam int MULT_W     = 10;
    localparam int STATUS_W   = 3;
    localparam int SLOT_W     = 10;
    localparam int HASH_W     = 10;
    localparam int PROBES_W   = 11;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [TE_W-1:0]   TE_RESET   = 11'd1000;
    localparam logic [MULT_W-1:0] MULT_RESET = 10'd123;
    localparam logic [CHAR_W-1:0] APOSTROPHE = 8'd39;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ENTRIES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER    = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        RES_INSERTED  = 3'd0,
        RES_DUPLICATE = 3'd1,
        RES_EMPTY     = 3'd2,
        RES_FULL      = 3'd3,
        RES_TOO_LONG  = 3'd4
    } res_code_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_END,
        ST_READ,
        ST_META,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_CMP_RD,
        ST_CMP_CHK,
        ST_RESULT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic      clr_step;
        logic      take;
        logic      div_step;
        logic      probe_start;
        logic      meta_rd;
        logic      meta_ins;
        logic      next_probe;
        logic      idx_clr;
        logic      idx_inc;
        logic      buf_rd;
        logic      chars_rd;
        logic      chars_wr;
        logic      set_code;
        res_code_t code;
        logic      res_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic in_hashed;
        logic in_last;
        logic div_last;
        logic last_q;
        logic overflow;
        logic len_zero;
        logic used;
        logic len_eq;
        logic probe_last;
        logic chars_eq;
        logic idx_last;
        logic out_free;
    } sts_t;

    // Punctuation other than the apostrophe is dropped
    function automatic logic is_dropped(input logic [CHAR_W-1:0] c);
        return (c != APOSTROPHE) &&
               (c inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96], [8'd123:8'd126]});
    endfunction

    // Letters and the apostrophe fold into the hash
    function automatic logic is_hashed(input logic [CHAR_W-1:0] c);
        return (c inside {[8'd65:8'd90], [8'd97:8'd122]}) || (c == APOSTROPHE);
    endfunction

endpackage

`default_nettype wire

>>> sv/word_hash_table_insert.sv
// Top level of the word hash table with linear probing.
// Depends on whti_pkg, whti_ctrl and whti_dp.
//
//  channel | direction | handshake               | payload
//  s_      | in        | s_tvalid / s_tready     | s_tdata char_code, s_tlast last_char
//  m_      | out       | m_tvalid / m_tready     | m_tdata slot/hash/probes, m_tuser status
//  cfg_    | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// After reset a clear pass empties the used map of every slot; no word is taken then.
// A dropped or unhashed character needs only ST_IDLE; a hashed one then runs the bit-serial
// remainder unit in ST_HASH, one dividend bit per step. A word end passes ST_END, then
// ST_READ and ST_META per probed slot, ST_CMP_RD and ST_CMP_CHK per compared character,
// ST_COPY_RD and ST_COPY_WR per copied character on insert; ST_RESULT loads the result register.
// A waiting result does not block the next characters; only the next word end waits.
`default_nettype none

module word_hash_table_insert #(
    parameter int TABLE_SIZE   = whti_pkg::TABLE_SIZE,
    parameter int MAX_WORD_LEN = whti_pkg::MAX_WORD_LEN
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [whti_pkg::CHAR_W-1:0]       s_tdata,   // [7:0] char_code
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [whti_pkg::M_TDATA_W-1:0]         m_tdata,   // [9:0] slot, [19:10] hash_value,
                                                              // [30:20] probes, [31] zero
    output logic [whti_pkg::STATUS_W-1:0]          m_tuser,   // [2:0] status
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [whti_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [whti_pkg::CFG_DATA_W-1:0]   cfg_data
);

    whti_pkg::cmd_t cmd;
    whti_pkg::sts_t sts;

    // Registers take every word at once
    assign cfg_ready = 1'b1;

    whti_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    whti_dp #(
        .TABLE_SIZE   (TABLE_SIZE),
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Discarded words carry no hash and no probe count
    a_no_probe_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == whti_pkg::RES_EMPTY || m_tuser == whti_pkg::RES_TOO_LONG)
        |-> m_tdata[30:10] == '0)
        else $error("discarded word reports hash or probes");

    // A placed or matched word took at least one probe
    a_probe_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == whti_pkg::RES_INSERTED || m_tuser == whti_pkg::RES_DUPLICATE)
        |-> m_tdata[30:20] != '0)
        else $error("inserted or duplicate word with zero probes");

    // A new result is only loaded while input is held off
    a_result_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result loaded while accepting input");

endmodule

`default_nettype wire

>>> sv/whti_ctrl.sv
// Sequencer for the word hash table: clear pass, hashing, probe walk.
// Depends on whti_pkg; drives whti_dp through cmd_t and reads sts_t.
`default_nettype none

module whti_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire whti_pkg::sts_t sts,
    output whti_pkg::cmd_t     cmd
);

    whti_pkg::state_t state_reg;
    whti_pkg::state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= whti_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            whti_pkg::ST_CLEAR: begin
                if (sts.clr_last) state_next = whti_pkg::ST_IDLE;
            end
            whti_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (sts.in_hashed)    state_next = whti_pkg::ST_HASH;
                    else if (sts.in_last) state_next = whti_pkg::ST_END;
                end
            end
            whti_pkg::ST_HASH: begin
                if (sts.div_last) begin
                    state_next = sts.last_q ? whti_pkg::ST_END : whti_pkg::ST_IDLE;
                end
            end
            whti_pkg::ST_END: begin
                if (sts.overflow || sts.len_zero) state_next = whti_pkg::ST_RESULT;
                else                              state_next = whti_pkg::ST_READ;
            end
            whti_pkg::ST_READ: begin
                state_next = whti_pkg::ST_META;
            end
            whti_pkg::ST_META: begin
                if (!sts.used)           state_next = whti_pkg::ST_COPY_RD;
                else if (sts.len_eq)     state_next = whti_pkg::ST_CMP_RD;
                else if (sts.probe_last) state_next = whti_pkg::ST_RESULT;
                else                     state_next = whti_pkg::ST_READ;
            end
            whti_pkg::ST_COPY_RD: begin
                state_next = whti_pkg::ST_COPY_WR;
            end
            whti_pkg::ST_COPY_WR: begin
                state_next = sts.idx_last ? whti_pkg::ST_RESULT : whti_pkg::ST_COPY_RD;
            end
            whti_pkg::ST_CMP_RD: begin
                state_next = whti_pkg::ST_CMP_CHK;
            end
            whti_pkg::ST_CMP_CHK: begin
                if (!sts.chars_eq) begin
                    state_next = sts.probe_last ? whti_pkg::ST_RESULT : whti_pkg::ST_READ;
                end else begin
                    state_next = sts.idx_last ? whti_pkg::ST_RESULT : whti_pkg::ST_CMP_RD;
                end
            end
            whti_pkg::ST_RESULT: begin
                if (sts.out_free) state_next = whti_pkg::ST_IDLE;
            end
            default: begin
                state_next = whti_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        cmd      = '0;
        cmd.code = whti_pkg::RES_INSERTED;
        s_tready = 1'b0;
        case (state_reg)
            whti_pkg::ST_CLEAR: begin
                cmd.clr_step = 1'b1;
            end
            whti_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            whti_pkg::ST_HASH: begin
                cmd.div_step = 1'b1;
            end
            whti_pkg::ST_END: begin
                cmd.probe_start = 1'b1;
                if (sts.overflow) begin
                    cmd.set_code = 1'b1;
                    cmd.code     = whti_pkg::RES_TOO_LONG;
                end else if (sts.len_zero) begin
                    cmd.set_code = 1'b1;
                    cmd.code     = whti_pkg::RES_EMPTY;
                end
            end
            whti_pkg::ST_READ: begin
                cmd.meta_rd = 1'b1;
            end
            whti_pkg::ST_META: begin
                cmd.idx_clr = 1'b1;
                if (!sts.used) begin
                    cmd.meta_ins = 1'b1;
                end else if (!sts.len_eq) begin
                    if (sts.probe_last) begin
                        cmd.set_code = 1'b1;
                        cmd.code     = whti_pkg::RES_FULL;
                    end else begin
                        cmd.next_probe = 1'b1;
                    end
                end
            end
            whti_pkg::ST_COPY_RD: begin
                cmd.buf_rd = 1'b1;
            end
            whti_pkg::ST_COPY_WR: begin
                cmd.chars_wr = 1'b1;
                if (sts.idx_last) begin
                    cmd.set_code = 1'b1;
                    cmd.code     = whti_pkg::RES_INSERTED;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            whti_pkg::ST_CMP_RD: begin
                cmd.buf_rd   = 1'b1;
                cmd.chars_rd = 1'b1;
            end
            whti_pkg::ST_CMP_CHK: begin
                if (!sts.chars_eq) begin
                    if (sts.probe_last) begin
                        cmd.set_code = 1'b1;
                        cmd.code     = whti_pkg::RES_FULL;
                    end else begin
                        cmd.next_probe = 1'b1;
                    end
                end else if (sts.idx_last) begin
                    cmd.set_code = 1'b1;
                    cmd.code     = whti_pkg::RES_DUPLICATE;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            whti_pkg::ST_RESULT: begin
                cmd.res_load = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/whti_dp.sv
// Datapath of the word hash table: config registers, hash divider, word buffer,
// slot tables and the result register. Depends on whti_pkg; driven by whti_ctrl.
`default_nettype none

module whti_dp #(
    parameter int TABLE_SIZE   = whti_pkg::TABLE_SIZE,
    parameter int MAX_WORD_LEN = whti_pkg::MAX_WORD_LEN
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    input  wire logic [whti_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [whti_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [whti_pkg::CHAR_W-1:0]       s_tdata,
    input  wire logic                              s_tlast,
    input  wire whti_pkg::cmd_t                    cmd,
    output whti_pkg::sts_t                         sts,
    input  wire logic                              m_tready,
    output logic                                   m_tvalid,
    output logic [whti_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic [whti_pkg::STATUS_W-1:0]          m_tuser
);

    localparam int IW     = $clog2(TABLE_SIZE);
    localparam int EW     = $clog2(TABLE_SIZE + 1);
    localparam int AW     = $clog2(MAX_WORD_LEN);
    localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
    localparam int DW     = IW + whti_pkg::MULT_W;
    localparam int DCW    = $clog2(DW + 1);
    localparam int CH_DEP = TABLE_SIZE * (2 ** AW);

    logic [whti_pkg::TE_W-1:0]   te_reg;
    logic [whti_pkg::MULT_W-1:0] mult_reg;
    logic [EW-1:0]               live_e;

    logic [LEN_W-1:0] len_reg;
    logic             ovf_reg;
    logic [IW-1:0]    hash_reg;
    logic             last_reg;
    logic [DW-1:0]    dvd_reg;
    logic [EW-1:0]    rem_reg;
    logic [DCW-1:0]   dcnt_reg;
    logic [IW-1:0]    pos_reg;
    logic [EW-1:0]    n_reg;
    logic [LEN_W-1:0] idx_reg;
    logic [IW-1:0]    clr_reg;
    whti_pkg::res_code_t code_reg;

    logic [whti_pkg::CHAR_W-1:0] buf_q_reg;
    logic [whti_pkg::CHAR_W-1:0] chr_q_reg;
    logic [LEN_W:0]              meta_q_reg;

    logic [whti_pkg::CHAR_W-1:0] buf_mem   [MAX_WORD_LEN];
    logic [whti_pkg::CHAR_W-1:0] chars_mem [CH_DEP];
    logic [LEN_W:0]              meta_mem  [TABLE_SIZE];

    logic                        m_tvalid_reg;
    logic [whti_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [whti_pkg::STATUS_W-1:0]  m_tuser_reg;

    logic          kept;
    logic          room;
    logic [DW-1:0] prod;
    logic [EW:0]   rem_sh;
    logic [EW:0]   rem_next;
    logic [EW-1:0] pos_inc;
    logic [EW-1:0] pos_start;
    logic [IW+AW-1:0] ch_addr;
    logic [whti_pkg::SLOT_W-1:0]   slot_o;
    logic [whti_pkg::HASH_W-1:0]   hash_o;
    logic [whti_pkg::PROBES_W-1:0] probes_o;
    logic          no_probe;

    // Clamp the entry count into 1..TABLE_SIZE
    always_comb begin
        if (te_reg == '0) begin
            live_e = EW'(1);
        end else if ({21'd0, te_reg} > 32'(TABLE_SIZE)) begin
            live_e = EW'(TABLE_SIZE);
        end else begin
            live_e = EW'(te_reg);
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            te_reg   <= whti_pkg::TE_RESET;
            mult_reg <= whti_pkg::MULT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                whti_pkg::CFG_TABLE_ENTRIES: te_reg   <= cfg_data;
                whti_pkg::CFG_MULTIPLIER:    mult_reg <= cfg_data[whti_pkg::MULT_W-1:0];
                default: ;
            endcase
        end
    end

    assign kept = !whti_pkg::is_dropped(s_tdata);
    assign room = len_reg < LEN_W'(MAX_WORD_LEN);
    assign prod = DW'(hash_reg) * DW'(mult_reg) + DW'(s_tdata);

    // One restoring remainder step per cycle
    assign rem_sh   = {rem_reg, dvd_reg[DW-1]};
    assign rem_next = (rem_sh >= {1'b0, live_e}) ? rem_sh - {1'b0, live_e} : rem_sh;

    assign pos_inc   = EW'(pos_reg) + EW'(1);
    assign pos_start = (EW'(hash_reg) >= live_e) ? '0 : EW'(hash_reg);
    assign ch_addr   = {pos_reg, idx_reg[AW-1:0]};

    // Word accumulation and hashing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
            hash_reg <= '0;
            dcnt_reg <= '0;
        end else if (cmd.res_load) begin
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
            hash_reg <= '0;
        end else if (cmd.take) begin
            if (kept) begin
                if (room) len_reg <= len_reg + LEN_W'(1);
                else      ovf_reg <= 1'b1;
            end
            if (whti_pkg::is_hashed(s_tdata)) dcnt_reg <= '0;
        end else if (cmd.div_step) begin
            dcnt_reg <= dcnt_reg + DCW'(1);
            if (sts.div_last) hash_reg <= IW'(rem_next);
        end
    end

    // Divider payload and end-of-word flag
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            last_reg <= s_tlast;
            dvd_reg  <= prod;
            rem_reg  <= '0;
        end else if (cmd.div_step) begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= EW'(rem_next);
        end
    end

    // Probe position, probe count and character index
    always_ff @(posedge aclk) begin
        if (cmd.probe_start) begin
            pos_reg <= IW'(pos_start);
            n_reg   <= EW'(1);
        end else if (cmd.next_probe) begin
            pos_reg <= (pos_inc >= live_e) ? '0 : IW'(pos_inc);
            n_reg   <= n_reg + EW'(1);
        end
        if (cmd.idx_clr)      idx_reg <= '0;
        else if (cmd.idx_inc) idx_reg <= idx_reg + LEN_W'(1);
        if (cmd.set_code)     code_reg <= cmd.code;
    end

    // Clear pass counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_reg <= clr_reg + IW'(1);
        end
    end

    // Word buffer
    always_ff @(posedge aclk) begin
        if (cmd.take && kept && room) buf_mem[len_reg[AW-1:0]] <= s_tdata;
        if (cmd.buf_rd) buf_q_reg <= buf_mem[idx_reg[AW-1:0]];
    end

    // Slot characters
    always_ff @(posedge aclk) begin
        if (cmd.chars_wr) chars_mem[ch_addr] <= buf_q_reg;
        if (cmd.chars_rd) chr_q_reg <= chars_mem[ch_addr];
    end

    // Slot used flag and length
    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            meta_mem[clr_reg] <= '0;
        end else if (cmd.meta_ins) begin
            meta_mem[pos_reg] <= {1'b1, len_reg};
        end
        if (cmd.meta_rd) meta_q_reg <= meta_mem[pos_reg];
    end

    // Result fields
    assign no_probe = (code_reg == whti_pkg::RES_EMPTY) || (code_reg == whti_pkg::RES_TOO_LONG);
    assign slot_o   = ((code_reg == whti_pkg::RES_INSERTED) ||
                       (code_reg == whti_pkg::RES_DUPLICATE)) ? whti_pkg::SLOT_W'(pos_reg) : '0;
    assign hash_o   = no_probe ? '0 : whti_pkg::HASH_W'(hash_reg);
    assign probes_o = no_probe ? '0 : whti_pkg::PROBES_W'(n_reg);

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            m_tdata_reg <= {1'b0, probes_o, hash_o, slot_o};
            m_tuser_reg <= code_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Status to the controller
    always_comb begin
        sts.clr_last   = clr_reg == IW'(TABLE_SIZE - 1);
        sts.in_hashed  = whti_pkg::is_hashed(s_tdata);
        sts.in_last    = s_tlast;
        sts.div_last   = dcnt_reg == DCW'(DW - 1);
        sts.last_q     = last_reg;
        sts.overflow   = ovf_reg;
        sts.len_zero   = len_reg == '0;
        sts.used       = meta_q_reg[LEN_W];
        sts.len_eq     = meta_q_reg[LEN_W-1:0] == len_reg;
        sts.probe_last = n_reg == live_e;
        sts.chars_eq   = buf_q_reg == chr_q_reg;
        sts.idx_last   = (idx_reg + LEN_W'(1)) == len_reg;
        sts.out_free   = !m_tvalid_reg || m_tready;
    end

endmodule

`default_nettype wire
